@@ sv/ack_gated_retransmit_tracker_assert.svh @@
// assertion macros for the ack gated retransmit tracker
// no dependencies; included by modules that carry concurrent checks
`ifndef ACK_GATED_RETRANSMIT_TRACKER_ASSERT_SVH
`define ACK_GATED_RETRANSMIT_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define AGRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("agrt same-cycle check failed");
`define AGRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("agrt next-cycle check failed");
`else
`define AGRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AGRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/agrt_pkg.sv @@
// shared types, codes and constants for the ack gated retransmit tracker
// no dependencies
package agrt_pkg;

    localparam int RING_SLOTS_DEF   = 64;
    localparam int CHANNELS_DEF     = 4;
    localparam int SAMPLE_STORE_DEF = 4096;

    localparam int CYCLE_W = 26;
    localparam int SEQ_W   = 16;
    localparam int IDX_W   = 32;
    localparam int CNT_W   = 8;
    localparam int CHAN_W  = 2;
    localparam int FUNC_W  = 3;
    localparam int LIMIT_W = 18;

    localparam int TIMEOUT_DIV     = 500;
    localparam int TIMEOUT_DEFAULT = 2000;
    localparam int TIMEOUT_MIN     = 200;

    localparam logic [FUNC_W-1:0] FN_START   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_STOP    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_TICK    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SEND    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_ACK     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_TIMEOUT = 3'd5;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [CHAN_W-1:0] chan;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  stamp;
    } agrt_rec_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAN_W-1:0] channel;
        logic [CNT_W-1:0]  req_count;
        logic [SEQ_W-1:0]  ack_sequence;
        logic [IDX_W-1:0]  now_ms;
    } agrt_req_t;

    typedef struct packed {
        logic              accepted;
        logic [SEQ_W-1:0]  sequence_res;
        logic [IDX_W-1:0]  first_index;
        logic [CNT_W-1:0]  granted_count;
        logic [5:0]        released;
        logic              rewound;
        logic              dropped;
        logic [5:0]        in_flight;
        logic [IDX_W-1:0]  overflows;
    } agrt_res_t;

    typedef struct packed {
        logic               busy;
        logic [LIMIT_W-1:0] limit;
    } agrt_limit_t;

endpackage

@@ sv/agrt_in_if.sv @@
// input word channel: valid, ready and the event fields
// depends on agrt_pkg
interface agrt_in_if;
    import agrt_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAN_W-1:0] channel;
    logic [CNT_W-1:0]  req_count;
    logic [SEQ_W-1:0]  ack_sequence;
    logic [IDX_W-1:0]  now_ms;

    modport source (output valid, func, channel, req_count, ack_sequence, now_ms,
                    input ready);
    modport sink (input valid, func, channel, req_count, ack_sequence, now_ms,
                  output ready);
endinterface

@@ sv/agrt_out_if.sv @@
// result word channel: valid, ready and the result fields
// depends on agrt_pkg
interface agrt_out_if;
    import agrt_pkg::*;

    logic             valid;
    logic             ready;
    logic             accepted;
    logic [SEQ_W-1:0] sequence_res;
    logic [IDX_W-1:0] first_index;
    logic [CNT_W-1:0] granted_count;
    logic [5:0]       released;
    logic             rewound;
    logic             dropped;
    logic [5:0]       in_flight;
    logic [IDX_W-1:0] overflows;

    modport source (output valid, accepted, sequence_res, first_index, granted_count,
                    released, rewound, dropped, in_flight, overflows,
                    input ready);
    modport sink (input valid, accepted, sequence_res, first_index, granted_count,
                  released, rewound, dropped, in_flight, overflows,
                  output ready);
endinterface

@@ sv/agrt_ring_mem.sv @@
// in-flight record ring: one write port, one registered read port
// depends on agrt_pkg
module agrt_ring_mem #(
    parameter int SLOTS = agrt_pkg::RING_SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(SLOTS)-1:0] waddr,
    input  agrt_pkg::agrt_rec_t      wdata,
    input  logic                     re,
    input  logic [$clog2(SLOTS)-1:0] raddr,
    output agrt_pkg::agrt_rec_t      rdata
);
    import agrt_pkg::*;

    agrt_rec_t mem [SLOTS];
    agrt_rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ sv/agrt_limit_div.sv @@
// retransmit timeout unit: cycle length / 500 by reciprocal multiply, then clamp
// depends on agrt_pkg
module agrt_limit_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [agrt_pkg::CYCLE_W-1:0] cycle_len,
    output agrt_pkg::agrt_limit_t        status
);
    import agrt_pkg::*;

    // ceil(2^35 / 500), exact quotient for any 26-bit dividend
    localparam int                 RECIP_W   = 27;
    localparam int                 RECIP_SH  = 35;
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(68719477);
    localparam int                 PROD_W    = CYCLE_W + RECIP_W;

    logic [PROD_W-1:0]  prod;
    logic [LIMIT_W-1:0] quo_reg;
    logic               busy_reg;
    logic               zero_reg;
    logic [LIMIT_W-1:0] limit_reg, limit_next;

    always_comb
    begin
        prod = PROD_W'(cycle_len) * PROD_W'(RECIP_MUL);
        if (zero_reg)
        begin
            limit_next = LIMIT_W'(TIMEOUT_DEFAULT);
        end
        else if (quo_reg < LIMIT_W'(TIMEOUT_MIN))
        begin
            limit_next = LIMIT_W'(TIMEOUT_MIN);
        end
        else
        begin
            limit_next = quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            limit_reg <= LIMIT_W'(TIMEOUT_DEFAULT);
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            busy_reg  <= 1'b0;
            limit_reg <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= prod[RECIP_SH +: LIMIT_W];
            zero_reg <= (cycle_len == '0);
        end
    end

    assign status.busy  = busy_reg;
    assign status.limit = limit_reg;
endmodule

@@ sv/ack_gated_retransmit_tracker.sv @@
// go-back-N sender window bookkeeping: sequencer, channel index registers,
// in-flight ring memory and timeout unit; depends on agrt_pkg, the channel
// interfaces, agrt_ring_mem, agrt_limit_div and the assertion header
//
// Each input word produces exactly one result word. Start, stop, sample tick,
// send, unknown codes and a timeout check that finds the sender stopped or the
// ring empty pass from the execute state straight to the done state; a timeout
// check with records in flight also reads the oldest record from the ring
// memory; an ack walks the ring from the tail, where each record is read from
// the ring, compared and retired before the next read is issued (up to
// RING_SLOTS-1 records), and the walk stops at the head or at a record not yet
// acknowledged. One word is worked on at a time; a new word is taken while the
// previous result still waits in the output register. Writing the cycle-length
// register starts a timeout update (reciprocal multiply by 1/500, then the
// clamp), and no input word is accepted until it ends. There is no clearing
// pass: only ring records between tail and head are ever read.
`include "ack_gated_retransmit_tracker_assert.svh"

module ack_gated_retransmit_tracker #(
    parameter int RING_SLOTS   = agrt_pkg::RING_SLOTS_DEF,
    parameter int CHANNELS     = agrt_pkg::CHANNELS_DEF,
    parameter int SAMPLE_STORE = agrt_pkg::SAMPLE_STORE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [agrt_pkg::CYCLE_W-1:0] cfg_wr_data,
    agrt_in_if.sink                      in_ch,
    agrt_out_if.source                   out_ch
);
    import agrt_pkg::*;

    localparam int IW   = $clog2(RING_SLOTS);
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [IDX_W-1:0] STORE_LIM = IDX_W'(SAMPLE_STORE - 1);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_EXEC    = 6'b000010,
        ST_ACK_RD  = 6'b000100,
        ST_ACK_CHK = 6'b001000,
        ST_TO_CHK  = 6'b010000,
        ST_DONE    = 6'b100000
    } agrt_state_t;

    agrt_state_t      state_reg, state_next;
    agrt_req_t        req_reg;
    agrt_res_t        res_reg, res_next;
    agrt_res_t        res_fin;
    agrt_res_t        out_reg;
    logic             out_valid_reg;
    logic             running_reg, running_next;
    logic [IDX_W-1:0] prod_reg [CHANNELS];
    logic [IDX_W-1:0] prod_next [CHANNELS];
    logic [IDX_W-1:0] sent_reg [CHANNELS];
    logic [IDX_W-1:0] sent_next [CHANNELS];
    logic [IDX_W-1:0] acked_reg [CHANNELS];
    logic [IDX_W-1:0] acked_next [CHANNELS];
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic [IW-1:0]    head_reg, head_next;
    logic [IW-1:0]    tail_reg, tail_next;
    logic [IW-1:0]    rel_reg, rel_next;
    logic [IDX_W-1:0] ovf_reg, ovf_next;

    logic [IW-1:0]    head_inc;
    logic [IW-1:0]    tail_inc;
    logic [IW:0]      used;
    logic             ring_full;
    logic             load_out;

    logic             mem_we;
    agrt_rec_t        mem_wdata;
    logic             mem_re;
    agrt_rec_t        mem_rdata;
    agrt_limit_t      lim;

    agrt_ring_mem #(
        .SLOTS (RING_SLOTS)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (head_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (tail_reg),
        .rdata (mem_rdata)
    );

    agrt_limit_div u_limit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_wr_en),
        .cycle_len (cfg_wr_data),
        .status    (lim)
    );

    assign head_inc  = (head_reg == IW'(RING_SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == IW'(RING_SLOTS - 1)) ? '0 : tail_reg + 1'b1;
    assign used      = (head_reg >= tail_reg)
                     ? ({1'b0, head_reg} - {1'b0, tail_reg})
                     : ({1'b0, head_reg} + (IW+1)'(RING_SLOTS) - {1'b0, tail_reg});
    assign ring_full = (head_inc == tail_reg);
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    assign in_ch.ready = (state_reg == ST_IDLE) && !lim.busy;

    always_comb
    begin
        logic             over;
        logic [CH_W-1:0]  ci;
        logic [IDX_W-1:0] pending;
        logic [CNT_W-1:0] grant;
        logic [SEQ_W-1:0] seq_gap;
        logic [IDX_W-1:0] upto;
        logic [CH_W-1:0]  rc;

        state_next   = state_reg;
        res_next     = res_reg;
        running_next = running_reg;
        prod_next    = prod_reg;
        sent_next    = sent_reg;
        acked_next   = acked_reg;
        seq_next     = seq_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        rel_next     = rel_reg;
        ovf_next     = ovf_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        over    = 1'b0;
        ci      = CH_W'(req_reg.channel);
        pending = prod_reg[ci] - sent_reg[ci];
        grant   = (IDX_W'(req_reg.req_count) < pending) ? req_reg.req_count
                                                        : pending[CNT_W-1:0];
        seq_gap = mem_rdata.seq - req_reg.ack_sequence;
        upto    = mem_rdata.first + IDX_W'(mem_rdata.count);
        rc      = CH_W'(mem_rdata.chan);

        mem_wdata.seq   = seq_reg;
        mem_wdata.chan  = req_reg.channel;
        mem_wdata.count = grant;
        mem_wdata.first = sent_reg[ci];
        mem_wdata.stamp = req_reg.now_ms;

        for (int c = 0; c < CHANNELS; c++)
        begin
            if (prod_reg[c] - acked_reg[c] >= STORE_LIM)
            begin
                over = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    res_next   = '0;
                    rel_next   = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (req_reg.func)
                    FN_START:
                    begin
                        if (!running_reg)
                        begin
                            for (int c = 0; c < CHANNELS; c++)
                            begin
                                prod_next[c]  = '0;
                                sent_next[c]  = '0;
                                acked_next[c] = '0;
                            end
                            head_next    = '0;
                            tail_next    = '0;
                            seq_next     = SEQ_W'(1);
                            ovf_next     = '0;
                            running_next = 1'b1;
                        end
                    end
                    FN_STOP:
                    begin
                        running_next = 1'b0;
                    end
                    FN_TICK:
                    begin
                        if (running_reg)
                        begin
                            if (over)
                            begin
                                res_next.dropped = 1'b1;
                                if (ovf_reg != '1)
                                begin
                                    ovf_next = ovf_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                for (int c = 0; c < CHANNELS; c++)
                                begin
                                    prod_next[c] = prod_reg[c] + 1'b1;
                                end
                                res_next.accepted = 1'b1;
                            end
                        end
                    end
                    FN_SEND:
                    begin
                        if (running_reg && (int'(req_reg.channel) < CHANNELS)
                            && (req_reg.req_count != '0) && !ring_full
                            && (pending != '0))
                        begin
                            mem_we                 = 1'b1;
                            head_next              = head_inc;
                            res_next.accepted      = 1'b1;
                            res_next.sequence_res  = seq_reg;
                            res_next.first_index   = sent_reg[ci];
                            res_next.granted_count = grant;
                            sent_next[ci]          = sent_reg[ci] + IDX_W'(grant);
                            seq_next               = seq_reg + 1'b1;
                        end
                    end
                    FN_ACK:
                    begin
                        state_next = ST_ACK_RD;
                    end
                    FN_TIMEOUT:
                    begin
                        if (running_reg && (used != '0))
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_TO_CHK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_ACK_RD:
            begin
                if (tail_reg == head_reg)
                begin
                    res_next.released = 6'(rel_reg);
                    state_next        = ST_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_ACK_CHK;
                end
            end
            ST_ACK_CHK:
            begin
                if ((seq_gap != '0) && !seq_gap[SEQ_W-1])
                begin
                    res_next.released = 6'(rel_reg);
                    state_next        = ST_DONE;
                end
                else
                begin
                    if ((int'(mem_rdata.chan) < CHANNELS) && (upto > acked_reg[rc]))
                    begin
                        acked_next[rc] = upto;
                    end
                    tail_next  = tail_inc;
                    rel_next   = rel_reg + 1'b1;
                    state_next = ST_ACK_RD;
                end
            end
            ST_TO_CHK:
            begin
                if ((req_reg.now_ms - mem_rdata.stamp) > IDX_W'(lim.limit))
                begin
                    seq_next = mem_rdata.seq;
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        sent_next[c] = acked_reg[c];
                    end
                    head_next             = '0;
                    tail_next             = '0;
                    res_next.rewound      = 1'b1;
                    res_next.sequence_res = mem_rdata.seq;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_fin           = res_reg;
        res_fin.in_flight = 6'(used);
        res_fin.overflows = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            running_reg   <= 1'b0;
            seq_reg       <= SEQ_W'(1);
            head_reg      <= '0;
            tail_reg      <= '0;
            rel_reg       <= '0;
            ovf_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                prod_reg[c]  <= '0;
                sent_reg[c]  <= '0;
                acked_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            seq_reg     <= seq_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            rel_reg     <= rel_next;
            ovf_reg     <= ovf_next;
            prod_reg    <= prod_next;
            sent_reg    <= sent_next;
            acked_reg   <= acked_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (in_ch.valid && in_ch.ready)
        begin
            req_reg <= {in_ch.func, in_ch.channel, in_ch.req_count,
                        in_ch.ack_sequence, in_ch.now_ms};
        end
        if (load_out)
        begin
            out_reg <= res_fin;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.accepted      = out_reg.accepted;
    assign out_ch.sequence_res  = out_reg.sequence_res;
    assign out_ch.first_index   = out_reg.first_index;
    assign out_ch.granted_count = out_reg.granted_count;
    assign out_ch.released      = out_reg.released;
    assign out_ch.rewound       = out_reg.rewound;
    assign out_ch.dropped       = out_reg.dropped;
    assign out_ch.in_flight     = out_reg.in_flight;
    assign out_ch.overflows     = out_reg.overflows;

    // checks on sequencer and ring bookkeeping
    `AGRT_ASSERT_NXT(a_one_word_at_a_time, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
    `AGRT_ASSERT_IMP(a_no_accept_while_div, clk, rst_n, lim.busy, !in_ch.ready)
    `AGRT_ASSERT_IMP(a_write_only_on_send, clk, rst_n, mem_we,
                     (state_reg == ST_EXEC) && (req_reg.func == FN_SEND) && !ring_full)
    `AGRT_ASSERT_IMP(a_ack_check_nonempty, clk, rst_n, state_reg == ST_ACK_CHK,
                     tail_reg != head_reg)
endmodule
